FILE: hw/rtl/kbt_pkg.sv
// Shared types and constants for the keyed block transposition core.
package kbt_pkg;

	localparam int CFG_WIDTH = 24;
	localparam int KEY_SLOTS = 8;
	localparam int KEY_BITS  = 3;

	typedef enum logic [2:0] {
		CFG_MODE        = 3'd0,
		CFG_BLOCK_LEN   = 3'd1,
		CFG_KEY_WORD    = 3'd2,
		CFG_PAD_CHAR    = 3'd3,
		CFG_STRIP_COUNT = 3'd4
	} cfg_idx_t;

	localparam logic        MODE_ENCRYPT    = 1'b0;
	localparam logic        MODE_DECRYPT    = 1'b1;
	localparam logic [3:0]  RST_BLOCK_LEN   = 4'd5;
	localparam logic [23:0] RST_KEY_WORD    = 24'd6338;
	localparam logic [7:0]  RST_PAD_CHAR    = 8'd122;
	localparam logic [3:0]  RST_STRIP_COUNT = 4'd0;

	typedef enum logic [1:0] {
		ST_FILL = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       last_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       last_out;
	} out_item_t;

	typedef logic [KEY_SLOTS-1:0][KEY_BITS-1:0] key_tab_t;

endpackage

FILE: hw/rtl/kbt_inv_key.sv
// Registered inverse-permutation table built from the key by rank ordering.
module kbt_inv_key (
	input  logic                 clk,
	input  logic [23:0]          key_word,
	input  logic [3:0]           grp_len,
	output kbt_pkg::key_tab_t    inv_q
);
	import kbt_pkg::*;

	logic [KEY_SLOTS-1:0][3:0] rank;
	key_tab_t                  inv_d;

	always_comb begin
		for (int i = 0; i < KEY_SLOTS; i++) begin
			rank[i] = 4'd0;
			for (int j = 0; j < KEY_SLOTS; j++) begin
				if (4'(j) < grp_len &&
				    (key_word[KEY_BITS*j +: KEY_BITS] < key_word[KEY_BITS*i +: KEY_BITS] ||
				     (key_word[KEY_BITS*j +: KEY_BITS] == key_word[KEY_BITS*i +: KEY_BITS]
				      && j < i))) begin
					rank[i] = rank[i] + 4'd1;
				end
			end
		end
		for (int m = 0; m < KEY_SLOTS; m++) begin
			inv_d[m] = '0;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				if (4'(i) < grp_len && rank[i] == 4'(m)) begin
					inv_d[m] = KEY_BITS'(i);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		inv_q <= inv_d;
	end

endmodule

FILE: hw/rtl/keyed_block_transposition_core.sv
// Keyed block transposition core: group buffer memory, emit sequencer and output register.
// Characters are taken one per cycle while a group is being collected; each one is
// written into the group memory. When a group fills, or the final character arrives,
// input stalls and the group is sent out in key order: each result is read from the
// synchronous memory, then loaded into the output register; the next read waits for that
// load and for the output register to be free or being taken. An encrypt message ending
// on a group boundary gets a full pad group. Encrypt pads the final group with pad_char;
// decrypt pads a partial final group and drops its last strip_count results. Results
// already in the output register drain while the next group is collected.
module keyed_block_transposition_core #(
	parameter int MAX_GROUP = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  kbt_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output kbt_pkg::out_item_t          out_data,
	input  logic                        cfg_we,
	input  logic [2:0]                  cfg_index,
	input  logic [kbt_pkg::CFG_WIDTH-1:0] cfg_wdata
);
	import kbt_pkg::*;

	localparam int LIM = (MAX_GROUP < 8) ? MAX_GROUP : 8;
	localparam int AW  = $clog2(MAX_GROUP);

	logic        mode_q;
	logic [3:0]  block_len_q;
	logic [23:0] key_word_q;
	logic [7:0]  pad_char_q;
	logic [3:0]  strip_count_q;

	state_t      state_q;
	logic [3:0]  fill_q;
	logic [3:0]  filled_q;
	logic [4:0]  total_q;
	logic [4:0]  cnt_q;
	logic        final_q;

	logic        s1_valid_s1;
	logic        s1_pad_s1;
	logic        s1_last_s1;
	logic [7:0]  rd_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic [7:0]  mem [MAX_GROUP];

	key_tab_t    inv_q;
	logic [3:0]  grp_len;
	logic [3:0]  fill_eff;
	logic [3:0]  new_fill;
	logic [3:0]  drop;
	logic [3:0]  keep_fin;
	logic        full;
	logic        accept;
	logic        start;
	logic [4:0]  emit_total;
	logic        issue;
	logic        second;
	logic [2:0]  pos;
	logic [2:0]  src;
	logic        pad;

	always_comb begin
		if (block_len_q == 4'd0) begin
			grp_len = 4'd1;
		end else if (block_len_q > 4'(LIM)) begin
			grp_len = 4'(LIM);
		end else begin
			grp_len = block_len_q;
		end
	end

	kbt_inv_key u_inv (
		.clk      (clk),
		.key_word (key_word_q),
		.grp_len  (grp_len),
		.inv_q    (inv_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_ENCRYPT;
			block_len_q   <= RST_BLOCK_LEN;
			key_word_q    <= RST_KEY_WORD;
			pad_char_q    <= RST_PAD_CHAR;
			strip_count_q <= RST_STRIP_COUNT;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MODE:        mode_q        <= cfg_wdata[0];
				CFG_BLOCK_LEN:   block_len_q   <= cfg_wdata[3:0];
				CFG_KEY_WORD:    key_word_q    <= cfg_wdata[23:0];
				CFG_PAD_CHAR:    pad_char_q    <= cfg_wdata[7:0];
				CFG_STRIP_COUNT: strip_count_q <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	assign in_ready = (state_q == ST_FILL);
	assign accept   = in_valid && in_ready;
	assign fill_eff = (fill_q >= grp_len) ? 4'd0 : fill_q;
	assign new_fill = fill_eff + 4'd1;
	assign full     = (new_fill >= grp_len);
	assign drop     = (mode_q != MODE_DECRYPT) ? 4'd0 :
	                  (strip_count_q > grp_len) ? grp_len : strip_count_q;
	assign keep_fin = grp_len - drop;

	always_comb begin
		if (!in_data.last_in) begin
			emit_total = full ? {1'b0, grp_len} : 5'd0;
		end else if (full && mode_q == MODE_ENCRYPT) begin
			emit_total = {grp_len, 1'b0};
		end else begin
			emit_total = {1'b0, keep_fin};
		end
	end

	assign start = accept && (emit_total != 5'd0);

	always_ff @(posedge clk) begin
		if (accept) begin
			mem[AW'(fill_eff)] <= in_data.char_in;
		end
	end

	assign second = (cnt_q >= {1'b0, grp_len});
	assign pos    = cnt_q[2:0];
	assign src    = (mode_q == MODE_DECRYPT) ? inv_q[pos] : key_word_q[KEY_BITS*pos +: KEY_BITS];
	assign pad    = second || ({1'b0, src} >= filled_q);
	assign issue  = (state_q == ST_EMIT) && !s1_valid_s1 && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_FILL;
			fill_q   <= 4'd0;
			filled_q <= 4'd0;
			total_q  <= 5'd0;
			cnt_q    <= 5'd0;
			final_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_FILL: begin
					if (accept) begin
						if (full || in_data.last_in) begin
							fill_q   <= 4'd0;
							filled_q <= full ? grp_len : new_fill;
							final_q  <= in_data.last_in;
							total_q  <= emit_total;
							cnt_q    <= 5'd0;
						end else begin
							fill_q <= new_fill;
						end
						if (start) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (issue) begin
						cnt_q <= cnt_q + 5'd1;
						if (cnt_q + 5'd1 == total_q) begin
							state_q <= ST_FILL;
						end
					end
				end
				default: state_q <= ST_FILL;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else begin
			s1_valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_q       <= mem[AW'(src)];
			s1_pad_s1  <= pad;
			s1_last_s1 <= final_q && (cnt_q + 5'd1 == total_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_valid_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_s1) begin
			out_q.char_out <= s1_pad_s1 ? pad_char_q : rd_q;
			out_q.last_out <= s1_last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: hw/rtl/kbt_checker.sv
// Port-level checker for the keyed block transposition core, bound to the top level.
module kbt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input kbt_pkg::in_item_t  in_data,
	input logic               out_valid,
	input logic               out_ready,
	input kbt_pkg::out_item_t out_data
);
	import kbt_pkg::*;

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input request changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result request changed while stalled");

	a_out_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid)
		else $error("result issued faster than the memory read allows");

	a_rst_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind keyed_block_transposition_core kbt_checker u_kbt_checker (.*);
